// File: sv/sradg_pkg.sv
// ---------------------------------------------------------------------------
// sradg_pkg
// shared types and constants for the strided row dma address generator
// ---------------------------------------------------------------------------
`default_nettype none

package sradg_pkg;

  localparam int POS_W     = 35;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_ROW      = 2'd1;
  localparam logic [1:0] STATUS_FAULT    = 2'd2;
  localparam logic [1:0] STATUS_IDLE     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_BYTES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MAP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_MAP     = 3'd4;

  // configuration reset values
  localparam logic [31:0] WINDOW_BASE_RESET  = 32'h1000_0000;
  localparam logic [31:0] SOURCE_BYTES_RESET = 32'd6291456;
  localparam logic [31:0] DEST_BYTES_RESET   = 32'd3072000;

  typedef struct packed {
    logic               opcode;
    logic [31:0]        source_start;
    logic [31:0]        dest_physical;
    logic signed [15:0] source_step;
    logic signed [15:0] dest_step;
    logic [15:0]        row_length;
    logic [15:0]        row_count;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] row_source;
    logic [31:0] row_dest;
    logic [15:0] row_bytes;
    logic        last_row;
  } out_word_t;

endpackage

`default_nettype wire

// File: sv/sradg_out_buf.sv
// ---------------------------------------------------------------------------
// sradg_out_buf
// result register with a skid stage, so a word can be taken in while the
// previous result still waits downstream
// ---------------------------------------------------------------------------
`default_nettype none

module sradg_out_buf (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push_valid,
  input  sradg_pkg::out_word_t push_word,
  output logic                 push_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sradg_pkg::out_word_t out_word
);

  logic                 skid_valid;
  sradg_pkg::out_word_t skid_word;
  logic                 push;
  logic                 load_out;

  assign push_stall = skid_valid;
  assign push       = push_valid && !skid_valid;
  // output register is free this cycle
  assign load_out   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word <= skid_valid ? skid_word : push_word;
    end
    if (!load_out && push) begin
      skid_word <= push_word;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && skid_valid) |=> skid_valid && out_valid)
    else $error("buffered word lost while stalled");
`endif

endmodule

`default_nettype wire

// File: sv/strided_row_dma_address_generator.sv
// ---------------------------------------------------------------------------
// strided_row_dma_address_generator
// turns a 2d row-copy descriptor into one row command per next-row request
// ---------------------------------------------------------------------------
//  channel  | handshake                 | word
//  ---------+---------------------------+------------------------------------
//  in       | in_valid / in_stall       | in_word   (load or next-row request)
//  out      | out_valid / out_stall     | out_word  (status and row command)
//  cfg      | cfg_write                 | cfg_index, cfg_data
//
//  one word in, one result out, one word per cycle sustained while out_stall is low
//  the descriptor state is updated at the cycle a word is taken in; the
//  result is registered in the output register, or in the skid stage while out_stall holds it
//  a skid stage behind the output register keeps input flowing for one
//  extra word while out_stall is high; in_stall rises only when it is full
//  rst is synchronous: clears descriptor state, restores window registers
// ---------------------------------------------------------------------------
`default_nettype none

module strided_row_dma_address_generator (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  sradg_pkg::in_word_t                   in_word,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output sradg_pkg::out_word_t                  out_word,
  input  wire                                   cfg_write,
  input  wire  [sradg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [sradg_pkg::CFG_DAT_W-1:0]       cfg_data
);

  // configuration
  logic [31:0] window_base_address;
  logic [31:0] source_window_bytes;
  logic [31:0] dest_window_bytes;
  logic        source_mapped;
  logic        dest_mapped;

  // descriptor state
  logic                                busy;
  logic signed [sradg_pkg::POS_W-1:0]  source_position;
  logic signed [sradg_pkg::POS_W-1:0]  dest_position;
  logic [15:0]                         rows_remaining;
  logic [15:0]                         held_length;
  logic signed [15:0]                  held_source_step;
  logic signed [15:0]                  held_dest_step;

  logic                                busy_next;
  logic signed [sradg_pkg::POS_W-1:0]  source_position_next;
  logic signed [sradg_pkg::POS_W-1:0]  dest_position_next;
  logic [15:0]                         rows_remaining_next;
  logic [15:0]                         held_length_next;
  logic signed [15:0]                  held_source_step_next;
  logic signed [15:0]                  held_dest_step_next;

  logic                 accept;
  sradg_pkg::out_word_t result;
  logic                 load_bad;
  logic [31:0]          rebased_dest;
  logic [sradg_pkg::POS_W-1:0] source_end;
  logic [sradg_pkg::POS_W-1:0] dest_end;
  logic                 row_bad;

  assign accept = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base_address <= sradg_pkg::WINDOW_BASE_RESET;
      source_window_bytes <= sradg_pkg::SOURCE_BYTES_RESET;
      dest_window_bytes   <= sradg_pkg::DEST_BYTES_RESET;
      source_mapped       <= 1'b0;
      dest_mapped         <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sradg_pkg::CFG_WINDOW_BASE:  window_base_address <= cfg_data;
        sradg_pkg::CFG_SOURCE_BYTES: source_window_bytes <= cfg_data;
        sradg_pkg::CFG_DEST_BYTES:   dest_window_bytes   <= cfg_data;
        sradg_pkg::CFG_SOURCE_MAP:   source_mapped       <= cfg_data[0];
        sradg_pkg::CFG_DEST_MAP:     dest_mapped         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign load_bad = !source_mapped || !dest_mapped ||
                    (in_word.row_length == 16'd0) || (in_word.row_count == 16'd0);
  assign rebased_dest = in_word.dest_physical - window_base_address;

  // positions stay below 2^34 in magnitude, so the low bits hold the value
  assign source_end = {1'b0, source_position[sradg_pkg::POS_W-2:0]} +
                      {{(sradg_pkg::POS_W-16){1'b0}}, held_length};
  assign dest_end   = {1'b0, dest_position[sradg_pkg::POS_W-2:0]} +
                      {{(sradg_pkg::POS_W-16){1'b0}}, held_length};
  assign row_bad = source_position[sradg_pkg::POS_W-1] ||
                   dest_position[sradg_pkg::POS_W-1] ||
                   (source_end > {{(sradg_pkg::POS_W-32){1'b0}}, source_window_bytes}) ||
                   (dest_end > {{(sradg_pkg::POS_W-32){1'b0}}, dest_window_bytes});

  always_comb begin
    busy_next             = busy;
    source_position_next  = source_position;
    dest_position_next    = dest_position;
    rows_remaining_next   = rows_remaining;
    held_length_next      = held_length;
    held_source_step_next = held_source_step;
    held_dest_step_next   = held_dest_step;
    result                = '0;

    if (in_word.opcode == sradg_pkg::OP_LOAD) begin
      if (load_bad) begin
        busy_next           = 1'b0;
        rows_remaining_next = 16'd0;
        result.status       = sradg_pkg::STATUS_FAULT;
      end else begin
        busy_next             = 1'b1;
        source_position_next  = {{(sradg_pkg::POS_W-32){1'b0}}, in_word.source_start};
        dest_position_next    = {{(sradg_pkg::POS_W-32){1'b0}}, rebased_dest};
        held_source_step_next = in_word.source_step;
        held_dest_step_next   = in_word.dest_step;
        held_length_next      = in_word.row_length;
        rows_remaining_next   = in_word.row_count;
        result.status         = sradg_pkg::STATUS_ACCEPTED;
      end
    end else if (!busy) begin
      result.status = sradg_pkg::STATUS_IDLE;
    end else if (row_bad) begin
      busy_next           = 1'b0;
      rows_remaining_next = 16'd0;
      result.status       = sradg_pkg::STATUS_FAULT;
    end else begin
      result.status       = sradg_pkg::STATUS_ROW;
      result.row_source   = source_position[31:0];
      result.row_dest     = dest_position[31:0];
      result.row_bytes    = held_length;
      result.last_row     = (rows_remaining == 16'd1);
      source_position_next = source_position +
        {{(sradg_pkg::POS_W-16){held_source_step[15]}}, held_source_step};
      dest_position_next   = dest_position +
        {{(sradg_pkg::POS_W-16){held_dest_step[15]}}, held_dest_step};
      rows_remaining_next  = rows_remaining - 16'd1;
      if (rows_remaining == 16'd1) begin
        busy_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      source_position  <= '0;
      dest_position    <= '0;
      rows_remaining   <= 16'd0;
      held_length      <= 16'd0;
      held_source_step <= 16'sd0;
      held_dest_step   <= 16'sd0;
    end else if (accept) begin
      busy             <= busy_next;
      source_position  <= source_position_next;
      dest_position    <= dest_position_next;
      rows_remaining   <= rows_remaining_next;
      held_length      <= held_length_next;
      held_source_step <= held_source_step_next;
      held_dest_step   <= held_dest_step_next;
    end
  end

  sradg_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_word  (result),
    .push_stall (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

`ifndef SYNTHESIS
  a_busy_has_rows: assert property (@(posedge clk) disable iff (rst)
    busy |-> rows_remaining != 16'd0)
    else $error("descriptor active with no rows left");

  a_last_row_ends: assert property (@(posedge clk) disable iff (rst)
    (accept && in_word.opcode == sradg_pkg::OP_NEXT && busy &&
     rows_remaining == 16'd1) |=> !busy)
    else $error("descriptor still active after its last row");

  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    (accept && in_word.opcode == sradg_pkg::OP_NEXT && !busy) |=>
      !busy && $stable(source_position) && $stable(dest_position))
    else $error("request with no descriptor changed state");

  a_fault_word_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status != sradg_pkg::STATUS_ROW) |->
      out_word.row_bytes == 16'd0 && !out_word.last_row)
    else $error("non-row result carries row fields");
`endif

endmodule

`default_nettype wire

// File: dv/tb_strided_row_dma_address_generator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_strided_row_dma_address_generator
// Self-checking bench for the strided row dma address generator. A predictor
// tracks the descriptor state and the window registers. Each word the block
// takes in gets one expected result, and each result the block hands out is
// checked against the oldest one. A directed section covers the rejects, the
// window limits and the register extremes. Random descriptors with random
// gaps and stalls follow.
// ---------------------------------------------------------------------------
module tb_strided_row_dma_address_generator;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_WORDS   = 1200;
  localparam int RANDOM_PHASES  = 8;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  sradg_pkg::in_word_t             in_word = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  sradg_pkg::out_word_t            out_word;
  logic                            cfg_write = 1'b0;
  logic [sradg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sradg_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  strided_row_dma_address_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // window registers as the block should hold them
  logic [31:0] win_base   = sradg_pkg::WINDOW_BASE_RESET;
  logic [31:0] src_window = sradg_pkg::SOURCE_BYTES_RESET;
  logic [31:0] dst_window = sradg_pkg::DEST_BYTES_RESET;
  logic        src_mapped = 1'b0;
  logic        dst_mapped = 1'b0;

  // descriptor state
  logic   desc_active = 1'b0;
  longint src_pos = 0;
  longint dst_pos = 0;
  int     rows_left = 0;
  int     held_len = 0;
  int     src_step = 0;
  int     dst_step = 0;

  sradg_pkg::out_word_t pending_commands[$];

  int unsigned words_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned config_phases = 0;
  int unsigned rows_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned idles_seen = 0;
  int unsigned accepts_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          sender_quiet = 1'b0;

  function automatic sradg_pkg::out_word_t next_row_command(input sradg_pkg::in_word_t w);
    sradg_pkg::out_word_t r;
    logic [31:0]          rebased;
    r = '0;
    if (w.opcode == sradg_pkg::OP_LOAD) begin
      if (!src_mapped || !dst_mapped || w.row_length == 0 || w.row_count == 0) begin
        desc_active = 1'b0;
        rows_left = 0;
        r.status = sradg_pkg::STATUS_FAULT;
      end else begin
        rebased = w.dest_physical - win_base;
        desc_active = 1'b1;
        src_pos = longint'(w.source_start);
        dst_pos = longint'(rebased);
        src_step = int'(w.source_step);
        dst_step = int'(w.dest_step);
        held_len = int'(w.row_length);
        rows_left = int'(w.row_count);
        r.status = sradg_pkg::STATUS_ACCEPTED;
      end
    end else if (!desc_active) begin
      r.status = sradg_pkg::STATUS_IDLE;
    end else if (src_pos < 0 || dst_pos < 0 ||
                 src_pos + held_len > longint'(src_window) ||
                 dst_pos + held_len > longint'(dst_window)) begin
      desc_active = 1'b0;
      rows_left = 0;
      r.status = sradg_pkg::STATUS_FAULT;
    end else begin
      r.status = sradg_pkg::STATUS_ROW;
      r.row_source = src_pos[31:0];
      r.row_dest = dst_pos[31:0];
      r.row_bytes = held_len[15:0];
      r.last_row = (rows_left == 1);
      src_pos += src_step;
      dst_pos += dst_step;
      rows_left--;
      if (rows_left == 0) desc_active = 1'b0;
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input sradg_pkg::in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_commands.push_back(next_row_command(w));
    words_sent++;
    if (w.opcode == sradg_pkg::OP_LOAD) loads_sent++;
  endtask

  // every word yields a result, so an empty queue means the block is idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sradg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      sradg_pkg::CFG_WINDOW_BASE:  win_base = data;
      sradg_pkg::CFG_SOURCE_BYTES: src_window = data;
      sradg_pkg::CFG_DEST_BYTES:   dst_window = data;
      sradg_pkg::CFG_SOURCE_MAP:   src_mapped = data[0];
      sradg_pkg::CFG_DEST_MAP:     dst_mapped = data[0];
      default: ;
    endcase
  endtask

  task automatic set_windows(input logic [31:0] base, input logic [31:0] src_bytes,
                             input logic [31:0] dst_bytes, input logic smap,
                             input logic dmap);
    wait_drained();
    write_reg(sradg_pkg::CFG_WINDOW_BASE, base);
    write_reg(sradg_pkg::CFG_SOURCE_BYTES, src_bytes);
    write_reg(sradg_pkg::CFG_DEST_BYTES, dst_bytes);
    write_reg(sradg_pkg::CFG_SOURCE_MAP, {31'b0, smap});
    write_reg(sradg_pkg::CFG_DEST_MAP, {31'b0, dmap});
    cfg_write <= 1'b0;
    config_phases++;
  endtask

  function automatic sradg_pkg::in_word_t load_word(input logic [31:0] src,
                                                    input logic [31:0] dst,
                                                    input logic [15:0] sstep,
                                                    input logic [15:0] dstep,
                                                    input logic [15:0] len,
                                                    input logic [15:0] cnt);
    sradg_pkg::in_word_t w;
    w.opcode = sradg_pkg::OP_LOAD;
    w.source_start = src;
    w.dest_physical = dst;
    w.source_step = sstep;
    w.dest_step = dstep;
    w.row_length = len;
    w.row_count = cnt;
    return w;
  endfunction

  // unused fields of a next-row word carry junk half of the time
  function automatic sradg_pkg::in_word_t next_word();
    sradg_pkg::in_word_t w;
    w = '0;
    if ($urandom_range(0, 1)) begin
      w = load_word($urandom, $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
    end
    w.opcode = sradg_pkg::OP_NEXT;
    return w;
  endfunction

  function automatic logic [15:0] pick_step(input int unsigned len);
    case ($urandom_range(0, 5))
      0: return 16'(len);
      1: return 16'(-int'(len));
      2: return 16'($urandom_range(0, 128) - 64);
      3: return 16'd0;
      4: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // well-formed descriptor whose first row fits the current windows unless a window is zero
  function automatic sradg_pkg::in_word_t make_descriptor();
    int unsigned len_cap, len, cnt, r;
    logic [31:0] src, rebased;
    len_cap = 65535;
    if (src_window < len_cap) len_cap = src_window;
    if (dst_window < len_cap) len_cap = dst_window;
    if (len_cap == 0) len_cap = 1;
    if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len_cap);
    else len = $urandom_range(1, (len_cap < 256) ? len_cap : 256);
    src = (src_window >= len) ? $urandom_range(0, src_window - len) : $urandom;
    rebased = (dst_window >= len) ? $urandom_range(0, dst_window - len) : $urandom;
    r = $urandom_range(0, 99);
    if (r < 70) cnt = $urandom_range(1, 8);
    else if (r < 96) cnt = $urandom_range(9, 48);
    else cnt = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 65535);
    return load_word(src, rebased + win_base, pick_step(len), pick_step(len),
                     16'(len), 16'(cnt));
  endfunction

  function automatic logic [31:0] pick_window();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom_range(1, 1024);
      3: return $urandom_range(1024, 32'h0080_0000);
      default: return $urandom_range(64, 32'h0004_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return sradg_pkg::WINDOW_BASE_RESET;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_no_descriptor();
    send_word(next_word());
    send_word(load_word(32'd0, sradg_pkg::WINDOW_BASE_RESET, 16'd16, 16'd16, 16'd16,
                        16'd2));
    send_word(next_word());
    set_windows(sradg_pkg::WINDOW_BASE_RESET, sradg_pkg::SOURCE_BYTES_RESET,
                sradg_pkg::DEST_BYTES_RESET, 1'b1, 1'b0);
    send_word(load_word(32'd0, sradg_pkg::WINDOW_BASE_RESET, 16'd16, 16'd16, 16'd16,
                        16'd2));
  endtask

  task automatic test_load_rejects();
    set_windows(sradg_pkg::WINDOW_BASE_RESET, sradg_pkg::SOURCE_BYTES_RESET,
                sradg_pkg::DEST_BYTES_RESET, 1'b1, 1'b1);
    send_word(load_word(32'd0, sradg_pkg::WINDOW_BASE_RESET, 16'd4, 16'd4, 16'd0, 16'd3));
    send_word(load_word(32'd0, sradg_pkg::WINDOW_BASE_RESET, 16'd4, 16'd4, 16'd4, 16'd0));
    send_word(load_word(32'd0, sradg_pkg::WINDOW_BASE_RESET, 16'd0, 16'd0, 16'hffff,
                        16'd1));
    send_word(next_word());
    send_word(next_word());
  endtask

  task automatic test_window_limits();
    // exceeds source window on the second row
    send_word(load_word(sradg_pkg::SOURCE_BYTES_RESET - 32'd16, sradg_pkg::WINDOW_BASE_RESET,
                        16'd1, 16'd0, 16'd16, 16'd4));
    send_word(next_word());
    send_word(next_word());
    send_word(next_word());
    // source goes negative
    send_word(load_word(32'd0, sradg_pkg::WINDOW_BASE_RESET + 32'd100, 16'hffff, 16'd0,
                        16'd8, 16'd3));
    send_word(next_word());
    send_word(next_word());
    // destination below the base wraps far past the window
    send_word(load_word(32'd0, sradg_pkg::WINDOW_BASE_RESET - 32'd1, 16'd0, 16'd0, 16'd8,
                        16'd3));
    send_word(next_word());
  endtask

  task automatic test_replace_and_remap();
    send_word(load_word(32'd64, sradg_pkg::WINDOW_BASE_RESET, 16'd32, 16'd64, 16'd32,
                        16'd5));
    send_word(next_word());
    send_word(load_word(32'd1000, sradg_pkg::WINDOW_BASE_RESET + 32'd500, 16'hfff0, 16'd8,
                        16'd4, 16'd2));
    send_word(next_word());
    send_word(next_word());
    // mapping is only looked at on load
    send_word(load_word(32'd0, sradg_pkg::WINDOW_BASE_RESET, 16'd8, 16'd8, 16'd8, 16'd3));
    send_word(next_word());
    set_windows(sradg_pkg::WINDOW_BASE_RESET, sradg_pkg::SOURCE_BYTES_RESET,
                sradg_pkg::DEST_BYTES_RESET, 1'b0, 1'b0);
    send_word(next_word());
  endtask

  task automatic test_register_extremes();
    set_windows(32'd0, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
    send_word(load_word(32'hffff_0000, 32'h7fff_0000, 16'h8000, 16'h7fff, 16'hffff,
                        16'hffff));
    send_word(next_word());
    send_word(next_word());
    send_word(load_word(32'hffff_ffff, 32'hffff_ffff, 16'd0, 16'd0, 16'd1, 16'd1));
    send_word(next_word());
    set_windows(32'hffff_ffff, 32'd0, 32'd0, 1'b1, 1'b1);
    send_word(load_word(32'd0, 32'hffff_ffff, 16'd1, 16'd1, 16'd1, 16'd1));
    send_word(next_word());
  endtask

  task automatic test_random_descriptors();
    int unsigned         per_phase, start, nreq, cnt;
    sradg_pkg::in_word_t junk;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_windows(pick_base(), pick_window(), pick_window(),
                  $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
      sender_quiet = ($urandom_range(0, 3) == 0);
      per_phase = RANDOM_WORDS / RANDOM_PHASES;
      start = words_sent;
      while (words_sent - start < per_phase) begin
        if ($urandom_range(0, 99) < 12) begin
          junk = load_word($urandom, $urandom, 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
          junk.opcode = $urandom_range(0, 1) ? sradg_pkg::OP_NEXT : sradg_pkg::OP_LOAD;
          send_word(junk);
        end else begin
          sradg_pkg::in_word_t d;
          d = make_descriptor();
          send_word(d);
          cnt = (d.row_count > 40) ? $urandom_range(1, 40) : d.row_count;
          case ($urandom_range(0, 4))
            0: nreq = $urandom_range(0, cnt);
            1: nreq = cnt + $urandom_range(1, 2);
            default: nreq = cnt;
          endcase
          for (int i = 0; i < nreq; i++) send_word(next_word());
        end
      end
    end
    sender_quiet = 1'b0;
  endtask

  // receiver: runs of stalls and runs of free flow, some of them long
  initial begin : receiver
    int unsigned hold;
    int unsigned r;
    logic stall_now;
    hold = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          stall_now = 1'b0;
          hold = $urandom_range(1, 8);
        end else if (r < 50) begin
          stall_now = 1'b0;
          hold = $urandom_range(50, 150);
        end else if (r < 92) begin
          stall_now = 1'b1;
          hold = $urandom_range(1, 3);
        end else begin
          stall_now = 1'b1;
          hold = $urandom_range(10, 40);
        end
      end
      out_stall <= stall_now;
    end
  end

  always @(posedge clk) begin
    sradg_pkg::out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_commands.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d src %h dst %h bytes %0d last %0d",
                   out_word.status, out_word.row_source, out_word.row_dest,
                   out_word.row_bytes, out_word.last_row);
      end else begin
        want = pending_commands.pop_front();
        if (out_word.status !== want.status || out_word.row_source !== want.row_source ||
            out_word.row_dest !== want.row_dest || out_word.row_bytes !== want.row_bytes ||
            out_word.last_row !== want.last_row) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected status %0d src %h dst %h bytes %0d last %0d",
                     want.status, want.row_source, want.row_dest, want.row_bytes,
                     want.last_row);
            $display("          got status %0d src %h dst %h bytes %0d last %0d",
                     out_word.status, out_word.row_source, out_word.row_dest,
                     out_word.row_bytes, out_word.last_row);
          end
        end
        case (want.status)
          sradg_pkg::STATUS_ACCEPTED: accepts_seen++;
          sradg_pkg::STATUS_ROW:      rows_seen++;
          sradg_pkg::STATUS_FAULT:    faults_seen++;
          default:                    idles_seen++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_strided_row_dma_address_generator: errors");
      $finish;
    end
  end

  initial begin : main
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_descriptor();
    test_load_rejects();
    test_window_limits();
    test_replace_and_remap();
    test_register_extremes();
    test_random_descriptors();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d words (%0d loads) over %0d register settings", words_sent,
             loads_sent, config_phases);
    $display("results: %0d accepted, %0d rows, %0d faults, %0d idle, %0d mismatches",
             accepts_seen, rows_seen, faults_seen, idles_seen, mismatches);
    if (mismatches == 0 && pending_commands.size() == 0) begin
      $display("tb_strided_row_dma_address_generator: clean");
    end else begin
      $display("tb_strided_row_dma_address_generator: errors");
    end
    $finish;
  end

endmodule
